>>> rtl/core/md5_pkg.sv
// Shared types, constants and round tables of the MD5 digest engine.
package md5_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_SEL,
        S_LOAD,
        S_RUN,
        S_ADD,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        M_DATA,
        M_PAD_LEN,
        M_PAD_MARK,
        M_ZERO_LEN
    } t_blk_mode;

    typedef struct packed {
        logic load;
        logic step;
        logic add;
        logic init;
    } t_rnd_ctl;

    localparam logic [31:0] C_IV_A       = 32'h67452301;
    localparam logic [31:0] C_IV_B       = 32'hEFCDAB89;
    localparam logic [31:0] C_IV_C       = 32'h98BADCFE;
    localparam logic [31:0] C_IV_D       = 32'h10325476;
    localparam logic [7:0]  C_PAD_BYTE   = 8'h80;
    localparam logic [5:0]  C_LEN_POS    = 6'd56;
    localparam logic [5:0]  C_LAST_POS   = 6'd63;
    localparam logic [5:0]  C_LAST_ROUND = 6'd63;
    localparam logic [63:0] C_BYTE_BITS  = 64'd8;

    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
            4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;
            4'd14: s = 5'd15;  4'd15: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_msg_idx(input logic [5:0] r);
        logic [3:0] x;
        logic [3:0] g;
        x = r[3:0];
        unique case (r[5:4])
            2'd0: g = x;
            2'd1: g = 4'(x * 4'd5 + 4'd1);
            2'd2: g = 4'(x * 4'd3 + 4'd5);
            2'd3: g = 4'(x * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

>>> rtl/core/md5_if.sv
// Handshake channels for message bytes in and digests out.
interface md5_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_item;

    modport source (output valid, output data_byte, output byte_present,
                    output last_item, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input last_item, output ready);
endinterface

interface md5_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_first;
    logic [63:0] digest_second;

    modport source (output valid, output digest_first, output digest_second,
                    input ready);
    modport sink (input valid, input digest_first, input digest_second,
                  output ready);
endinterface

>>> rtl/core/md5_block_buf.sv
// Sixteen-word message block store with padding and length insertion on read.
module md5_block_buf (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [5:0]               i_wr_pos,
    input  logic [7:0]               i_wr_byte,
    input  logic [3:0]               i_rd_idx,
    input  md5_pkg::t_blk_mode       i_mode,
    input  logic [5:0]               i_pad_pos,
    input  logic [63:0]              i_bit_len,
    output logic [31:0]              o_rd_word
);

    logic [31:0] r_words [16];
    logic [31:0] raw_word;
    logic [31:0] pad_word;
    logic [5:0]  byte_pos [4];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_words[i_wr_pos[5:2]][8 * i_wr_pos[1:0] +: 8] <= i_wr_byte;
        end
    end

    assign raw_word = r_words[i_rd_idx];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            byte_pos[j] = {i_rd_idx, 2'(j)};
            if (byte_pos[j] < i_pad_pos) begin
                pad_word[8 * j +: 8] = raw_word[8 * j +: 8];
            end else if (byte_pos[j] == i_pad_pos) begin
                pad_word[8 * j +: 8] = md5_pkg::C_PAD_BYTE;
            end else begin
                pad_word[8 * j +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        unique case (i_mode)
            md5_pkg::M_DATA: begin
                o_rd_word = raw_word;
            end
            md5_pkg::M_PAD_MARK: begin
                o_rd_word = pad_word;
            end
            md5_pkg::M_PAD_LEN, md5_pkg::M_ZERO_LEN: begin
                if (i_rd_idx == 4'd14) begin
                    o_rd_word = i_bit_len[31:0];
                end else if (i_rd_idx == 4'd15) begin
                    o_rd_word = i_bit_len[63:32];
                end else if (i_mode == md5_pkg::M_PAD_LEN) begin
                    o_rd_word = pad_word;
                end else begin
                    o_rd_word = 32'h0;
                end
            end
        endcase
    end

endmodule

>>> rtl/core/md5_round_unit.sv
// Shared MD5 round datapath with working and chaining registers.
module md5_round_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  md5_pkg::t_rnd_ctl   i_ctl,
    input  logic [5:0]          i_round,
    input  logic [31:0]         i_msg_word,
    output logic [127:0]        o_digest
);

    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_ca, r_cb, r_cc, r_cd;
    logic [31:0] f_val;
    logic [31:0] t_sum;
    logic [63:0] rot_wide;
    logic [31:0] n_b;

    always_comb begin
        unique case (i_round[5:4])
            2'd0: f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1: f_val = (r_b & r_d) | (r_c & ~r_d);
            2'd2: f_val = r_b ^ r_c ^ r_d;
            2'd3: f_val = r_c ^ (r_b | ~r_d);
        endcase
        t_sum    = r_a + f_val + i_msg_word + md5_pkg::md5_k(i_round);
        rot_wide = {t_sum, t_sum} << md5_pkg::md5_rot(i_round);
        n_b      = r_b + rot_wide[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_ca;
            r_b <= r_cb;
            r_c <= r_cc;
            r_d <= r_cd;
        end else if (i_ctl.step) begin
            r_a <= r_d;
            r_b <= n_b;
            r_c <= r_b;
            r_d <= r_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_ca <= md5_pkg::C_IV_A;
            r_cb <= md5_pkg::C_IV_B;
            r_cc <= md5_pkg::C_IV_C;
            r_cd <= md5_pkg::C_IV_D;
        end else if (i_ctl.add) begin
            r_ca <= r_ca + r_a;
            r_cb <= r_cb + r_b;
            r_cc <= r_cc + r_c;
            r_cd <= r_cd + r_d;
        end
    end

    assign o_digest = {md5_pkg::md5_bswap(r_ca), md5_pkg::md5_bswap(r_cb),
                       md5_pkg::md5_bswap(r_cc), md5_pkg::md5_bswap(r_cd)};

endmodule

>>> rtl/core/md5_digest_engine.sv
// Top level of the MD5 digest engine: sequencer, bit counter and output register.
//
// Message bytes arrive on i_item, one word per handshake; a word may carry a
// byte (byte_present), end the message (last_item), or both, the byte first.
// A word that neither completes a 64-byte block nor ends the message is taken
// without holding i_item.ready low afterwards. A word that completes a block
// holds i_item.ready low while the single round unit runs 64 rounds, one per
// cycle, plus one load and one chaining add.
// A word with last_item set appends padding and the bit length and shows the
// digest on o_digest after one more block pass, or after two when the
// padding spills into a second block; a byte that also fills its block adds
// its own block pass before that.
// Reset clears the bit counter, loads the MD5 initial chaining words and
// empties the output register; the block store itself needs no clearing.
// The digest waits in the output register while o_digest.ready is low and
// new bytes are still taken; a further digest waits until the register is
// free. After each digest the chaining state and bit counter start over.
module md5_digest_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    md5_item_if.sink             i_item,
    md5_digest_if.source         o_digest
);

    md5_pkg::t_state      r_state, n_state;
    md5_pkg::t_blk_mode   r_mode, n_mode;
    logic                 r_last, n_last;
    logic [5:0]           r_round;
    logic [63:0]          r_bit_total;
    logic                 r_out_valid;
    logic [63:0]          r_out_first;
    logic [63:0]          r_out_second;
    md5_pkg::t_rnd_ctl    rnd_ctl;
    logic                 in_accept;
    logic                 slot_free;
    logic [5:0]           byte_pos;
    logic [31:0]          msg_word;
    logic [127:0]         chain_digest;

    assign byte_pos  = r_bit_total[8:3];
    assign in_accept = i_item.valid && i_item.ready;
    assign slot_free = !r_out_valid || o_digest.ready;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_last  = r_last;
        unique case (r_state)
            md5_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    n_last = i_item.last_item;
                    if (i_item.byte_present && byte_pos == md5_pkg::C_LAST_POS) begin
                        n_mode  = md5_pkg::M_DATA;
                        n_state = md5_pkg::S_LOAD;
                    end else if (i_item.last_item) begin
                        n_state = md5_pkg::S_PAD_SEL;
                    end
                end
            end
            md5_pkg::S_PAD_SEL: begin
                n_mode  = (byte_pos < md5_pkg::C_LEN_POS) ? md5_pkg::M_PAD_LEN
                                                          : md5_pkg::M_PAD_MARK;
                n_state = md5_pkg::S_LOAD;
            end
            md5_pkg::S_LOAD: begin
                n_state = md5_pkg::S_RUN;
            end
            md5_pkg::S_RUN: begin
                if (r_round == md5_pkg::C_LAST_ROUND) begin
                    n_state = md5_pkg::S_ADD;
                end
            end
            md5_pkg::S_ADD: begin
                unique case (r_mode)
                    md5_pkg::M_DATA: begin
                        n_state = r_last ? md5_pkg::S_PAD_SEL : md5_pkg::S_IDLE;
                    end
                    md5_pkg::M_PAD_MARK: begin
                        n_mode  = md5_pkg::M_ZERO_LEN;
                        n_state = md5_pkg::S_LOAD;
                    end
                    md5_pkg::M_PAD_LEN, md5_pkg::M_ZERO_LEN: begin
                        n_state = md5_pkg::S_EMIT;
                    end
                endcase
            end
            md5_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_state = md5_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = md5_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_item.ready = (r_state == md5_pkg::S_IDLE);
        rnd_ctl.load = (r_state == md5_pkg::S_LOAD);
        rnd_ctl.step = (r_state == md5_pkg::S_RUN);
        rnd_ctl.add  = (r_state == md5_pkg::S_ADD);
        rnd_ctl.init = (r_state == md5_pkg::S_EMIT) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= md5_pkg::S_IDLE;
            r_mode      <= md5_pkg::M_DATA;
            r_last      <= 1'b0;
            r_round     <= 6'd0;
            r_bit_total <= 64'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_last  <= n_last;
            if (rnd_ctl.load) begin
                r_round <= 6'd0;
            end else if (rnd_ctl.step) begin
                r_round <= r_round + 6'd1;
            end
            if (rnd_ctl.init) begin
                r_bit_total <= 64'd0;
            end else if (in_accept && i_item.byte_present) begin
                r_bit_total <= r_bit_total + md5_pkg::C_BYTE_BITS;
            end
            if (rnd_ctl.init) begin
                r_out_valid <= 1'b1;
            end else if (o_digest.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rnd_ctl.init) begin
            r_out_first  <= chain_digest[127:64];
            r_out_second <= chain_digest[63:0];
        end
    end

    md5_block_buf u_block_buf (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept && i_item.byte_present),
        .i_wr_pos  (byte_pos),
        .i_wr_byte (i_item.data_byte),
        .i_rd_idx  (md5_pkg::md5_msg_idx(r_round)),
        .i_mode    (r_mode),
        .i_pad_pos (byte_pos),
        .i_bit_len (r_bit_total),
        .o_rd_word (msg_word)
    );

    md5_round_unit u_round_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (rnd_ctl),
        .i_round    (r_round),
        .i_msg_word (msg_word),
        .o_digest   (chain_digest)
    );

    assign o_digest.valid         = r_out_valid;
    assign o_digest.digest_first  = r_out_first;
    assign o_digest.digest_second = r_out_second;

endmodule

>>> rtl/core/md5_digest_engine_chk.sv
// Port-level checks of the MD5 digest engine and their bind to the top level.
module md5_digest_engine_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_first,
    input logic [63:0] i_out_second
);

    a_reset_empties_output: assert property (
        @(posedge i_clk) !i_rst_n |=> !i_out_valid
    ) else $error("digest valid after reset");

    a_stalled_digest_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_first) && $stable(i_out_second)
    ) else $error("stalled digest changed");

    a_last_word_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready
    ) else $error("input taken right after a final word");

    a_no_instant_digest: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid)
    ) else $error("digest appeared one cycle after an input word");

endmodule

bind md5_digest_engine md5_digest_engine_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_in_last    (i_item.last_item),
    .i_out_valid  (o_digest.valid),
    .i_out_ready  (o_digest.ready),
    .i_out_first  (o_digest.digest_first),
    .i_out_second (o_digest.digest_second)
);

>>> sim/tb_md5_digest_engine.sv
// Testbench for the MD5 digest engine: random and boundary-length messages checked by a shadow model.
module tb_md5_digest_engine;

    localparam int unsigned IDLE_PCT    = 29;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned ITEM_TARGET = 1350;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 200;

    localparam logic [0:63][31:0] ROUND_K = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [0:15][4:0] ROUND_ROT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    class md5_digest_tracker;
        logic [31:0]  h_words [4];
        logic [31:0]  msg_words [16];
        logic [63:0]  bit_count;
        logic [127:0] want_digests [$];
        int unsigned  fails;

        function new();
            foreach (msg_words[i]) msg_words[i] = '0;
            restart();
            fails = 0;
        endfunction

        function void restart();
            h_words[0] = md5_pkg::C_IV_A;
            h_words[1] = md5_pkg::C_IV_B;
            h_words[2] = md5_pkg::C_IV_C;
            h_words[3] = md5_pkg::C_IV_D;
            bit_count = '0;
        endfunction

        function void put_byte(logic [5:0] pos, logic [7:0] v);
            msg_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] = v;
        endfunction

        function logic [31:0] flip_bytes(logic [31:0] x);
            return {x[7:0], x[15:8], x[23:16], x[31:24]};
        endfunction

        function void run_rounds();
            logic [31:0] a, b, c, d, f, t;
            logic [3:0]  g;
            logic [4:0]  s;
            a = h_words[0];
            b = h_words[1];
            c = h_words[2];
            d = h_words[3];
            for (int r = 0; r < 64; r++) begin
                case (r / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = 4'(r);
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        g = 4'(5 * r + 1);
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = 4'(3 * r + 5);
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = 4'(7 * r);
                    end
                endcase
                s = ROUND_ROT[(r / 16) * 4 + r % 4];
                t = a + f + msg_words[g] + ROUND_K[r];
                a = d;
                d = c;
                c = b;
                b = c + ((t << s) | (t >> (32 - s)));
            end
            h_words[0] += a;
            h_words[1] += b;
            h_words[2] += c;
            h_words[3] += d;
        endfunction

        function void note_word(logic [7:0] d, logic present, logic last);
            logic [5:0] pos;
            if (present) begin
                pos = bit_count[8:3];
                put_byte(pos, d);
                bit_count += 64'd8;
                if (pos == md5_pkg::C_LAST_POS) run_rounds();
            end
            if (last) begin
                pos = bit_count[8:3];
                put_byte(pos, md5_pkg::C_PAD_BYTE);
                for (int i = int'(pos) + 1; i < 64; i++) put_byte(6'(i), 8'h00);
                // The length field does not fit behind the pad byte, so an extra block follows.
                if (pos >= md5_pkg::C_LEN_POS) begin
                    run_rounds();
                    foreach (msg_words[i]) msg_words[i] = '0;
                end
                msg_words[14] = bit_count[31:0];
                msg_words[15] = bit_count[63:32];
                run_rounds();
                want_digests.push_back({flip_bytes(h_words[0]), flip_bytes(h_words[1]),
                                        flip_bytes(h_words[2]), flip_bytes(h_words[3])});
                restart();
            end
        endfunction

        function void check_digest(logic [63:0] first, logic [63:0] second);
            logic [127:0] want;
            if (want_digests.size() == 0) begin
                $display("%0t: unexpected digest, expected none, got %h %h",
                         $time, first, second);
                fails++;
                return;
            end
            want = want_digests.pop_front();
            if (first !== want[127:64]) begin
                $display("%0t: digest_first mismatch, expected %h, got %h",
                         $time, want[127:64], first);
                fails++;
            end
            if (second !== want[63:0]) begin
                $display("%0t: digest_second mismatch, expected %h, got %h",
                         $time, want[63:0], second);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    md5_item_if   item_ch ();
    md5_digest_if digest_ch ();

    md5_digest_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_digest (digest_ch)
    );

    md5_digest_tracker tracker;
    bit                calm_stretch;
    bit                hold_req;
    int unsigned       words_sent;
    int unsigned       stall_cycles;

    always #2 i_clk = ~i_clk;

    task automatic push_word(logic [7:0] d, logic present, logic last);
        while (!calm_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
            item_ch.valid        <= 1'b0;
            item_ch.data_byte    <= 8'($urandom);
            item_ch.byte_present <= 1'($urandom);
            item_ch.last_item    <= 1'($urandom);
            @(negedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.data_byte    <= d;
        item_ch.byte_present <= present;
        item_ch.last_item    <= last;
        do @(posedge i_clk); while (!item_ch.ready);
        tracker.note_word(d, present, last);
        @(negedge i_clk);
    endtask

    task automatic send_message(int unsigned len, bit empty_end);
        logic closing;
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 4) push_word(8'($urandom), 1'b0, 1'b0);
            closing = !empty_end && (i == len - 1);
            push_word(8'($urandom), 1'b1, closing);
            words_sent++;
        end
        if (empty_end || len == 0) begin
            push_word(8'($urandom), 1'b0, 1'b1);
            words_sent++;
        end
    endtask

    task automatic wait_digests_home();
        item_ch.valid <= 1'b0;
        do @(negedge i_clk); while (tracker.want_digests.size() != 0);
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, 12);
        if (r < 65) return $urandom_range(53, 58);
        if (r < 77) return $urandom_range(62, 66);
        if (r < 85) return $urandom_range(117, 122);
        return $urandom_range(13, 52);
    endfunction

    initial begin
        digest_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                digest_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            digest_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (digest_ch.valid && digest_ch.ready) begin
                tracker.check_digest(digest_ch.digest_first, digest_ch.digest_second);
            end
            if ((digest_ch.valid && digest_ch.ready) || (item_ch.valid && item_ch.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, stall_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int unsigned edge_lens [8];
        edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        tracker = new();
        calm_stretch = 1'b0;
        hold_req = 1'b0;
        words_sent = 0;
        stall_cycles = 0;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data_byte = 8'h00;
        item_ch.byte_present = 1'b0;
        item_ch.last_item = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_word(8'hA5, 1'b0, 1'b0);
        push_word(8'h3C, 1'b0, 1'b1);
        push_word(8'h00, 1'b1, 1'b1);
        push_word(8'hFF, 1'b1, 1'b1);
        push_word(8'h61, 1'b1, 1'b0);
        push_word(8'h62, 1'b1, 1'b0);
        push_word(8'h63, 1'b1, 1'b1);
        push_word(8'h5A, 1'b1, 1'b0);
        push_word(8'hA5, 1'b0, 1'b0);
        push_word(8'hC3, 1'b0, 1'b1);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);

        foreach (edge_lens[i]) send_message(edge_lens[i], 1'($urandom));

        calm_stretch = 1'b1;
        repeat (8) send_message(pick_len(), 1'($urandom));
        calm_stretch = 1'b0;

        // Short messages pile up behind a held digest until the input stalls.
        hold_req = 1'b1;
        calm_stretch = 1'b1;
        repeat (6) send_message($urandom_range(0, 3), 1'($urandom));
        calm_stretch = 1'b0;
        wait_digests_home();

        while (words_sent < ITEM_TARGET) begin
            send_message(pick_len(), $urandom_range(0, 99) < 30);
        end
        item_ch.valid <= 1'b0;
        while (tracker.want_digests.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (tracker.fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
